>>> src/sphb_pkg.sv
// ----------------------------------------------------------------------------
// sphb_pkg: spectrum peak hold with band sums, shared definitions
// Widths, register codes, reset values and pipeline tag types.
// ----------------------------------------------------------------------------
`default_nettype none

package sphb_pkg;

	localparam int MAG_W       = 16;
	localparam int IDX_W       = 8;
	localparam int BAND_CNT_W  = 9;
	localparam int DECAY_W     = 16;
	localparam int SUM_W       = 24;
	localparam int PROD_W      = MAG_W + DECAY_W;
	localparam int STORE_DEPTH = 256;
	localparam int MAX_BANDS   = 256;
	localparam int BAND_MIN    = 4;
	localparam int BAND_TOP    = (MAX_BANDS < STORE_DEPTH) ? MAX_BANDS : STORE_DEPTH;
	localparam int NUM_QTR     = 4;
	localparam int QTR_W       = 2;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd1;

	localparam logic [BAND_CNT_W-1:0] BAND_COUNT_RST   = 9'd128;
	localparam logic [DECAY_W-1:0]    DECAY_FACTOR_RST = 16'd62915;

	typedef logic [MAG_W-1:0] mag_t;
	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [SUM_W-1:0] sum_t;
	typedef logic [QTR_W-1:0] qtr_t;

	// per-item control info that travels down the pipeline
	typedef struct packed {
		idx_t idx;
		logic last;
		qtr_t qtr;
	} band_tag_t;

	// frame report fields
	typedef struct packed {
		sum_t total;
		sum_t q1;
		sum_t q2;
		sum_t q3;
		sum_t q4;
	} band_report_t;

endpackage

`default_nettype wire

>>> src/sphb_in_if.sv
// ----------------------------------------------------------------------------
// sphb_in_if: magnitude input channel
// Valid/ready channel carrying one band magnitude per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface sphb_in_if;
	import sphb_pkg::*;

	logic valid;
	logic ready;
	mag_t magnitude;

	modport source (output valid, output magnitude, input ready);
	modport sink   (input valid, input magnitude, output ready);
endinterface

`default_nettype wire

>>> src/sphb_out_if.sv
// ----------------------------------------------------------------------------
// sphb_out_if: band result channel
// Valid/ready channel carrying one smoothed band and the frame sums.
// ----------------------------------------------------------------------------
`default_nettype none

interface sphb_out_if;
	import sphb_pkg::*;

	logic valid;
	logic ready;
	idx_t band_index;
	mag_t smoothed;
	logic frame_done;
	sum_t total_sum;
	sum_t quarter_one_sum;
	sum_t quarter_two_sum;
	sum_t quarter_three_sum;
	sum_t quarter_four_sum;

	modport source (output valid, output band_index, output smoothed, output frame_done,
		output total_sum, output quarter_one_sum, output quarter_two_sum,
		output quarter_three_sum, output quarter_four_sum, input ready);
	modport sink   (input valid, input band_index, input smoothed, input frame_done,
		input total_sum, input quarter_one_sum, input quarter_two_sum,
		input quarter_three_sum, input quarter_four_sum, output ready);
endinterface

`default_nettype wire

>>> src/spectrum_peak_hold_band_sums.sv
// Datapath: an accepted magnitude goes through the stage 1 read, stage 2 product and result registers to result valid.
// Throughput: one band per cycle; the pipeline stalls only on output backpressure.
// Critical path: 16x16 peak*decay multiply between the read and product registers.
// Reset: control, config and accumulators cleared; the peak store reads as zero
// through per-entry valid bits cleared at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// spectrum_peak_hold_band_sums: spectrum peak hold with decay and band sums
// Per band: decayed held peak vs. incoming magnitude, max is emitted and
// stored; frame total and quarter sums reported on the last band.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_peak_hold_band_sums (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [sphb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sphb_pkg::CFG_DATA_W-1:0] cfg_data,
	sphb_in_if.sink                           spec_in,
	sphb_out_if.source                        res_out
);
	import sphb_pkg::*;

	localparam int THR_W = BAND_CNT_W + 2;

	// configuration
	logic [BAND_CNT_W-1:0] band_count_q;
	logic [DECAY_W-1:0]    decay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_count_q <= BAND_COUNT_RST;
			decay_q      <= DECAY_FACTOR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BAND_COUNT:   band_count_q <= cfg_data[BAND_CNT_W-1:0];
				CFG_DECAY_FACTOR: decay_q      <= cfg_data[DECAY_W-1:0];
				default: ;
			endcase
		end
	end

	// effective band count and quarter boundaries
	logic [BAND_CNT_W-1:0] n_eff;
	logic [THR_W-1:0]      n3;
	logic [BAND_CNT_W-1:0] thr1, thr2, thr3;
	logic [BAND_CNT_W-1:0] idx_ext;
	idx_t                  cnt_q;
	band_tag_t             tag_in;

	always_comb begin
		if (band_count_q < BAND_CNT_W'(BAND_MIN)) begin
			n_eff = BAND_CNT_W'(BAND_MIN);
		end else if (band_count_q > BAND_CNT_W'(BAND_TOP)) begin
			n_eff = BAND_CNT_W'(BAND_TOP);
		end else begin
			n_eff = band_count_q;
		end
	end

	assign n3      = {2'b00, n_eff} + {1'b0, n_eff, 1'b0};
	assign thr1    = n_eff >> 2;
	assign thr2    = n_eff >> 1;
	assign thr3    = n3[THR_W-1:2];
	assign idx_ext = BAND_CNT_W'(cnt_q);

	always_comb begin
		tag_in.idx  = cnt_q;
		tag_in.last = (idx_ext >= n_eff - BAND_CNT_W'(1));
		priority if (idx_ext < thr1) begin
			tag_in.qtr = QTR_W'(0);
		end else if (idx_ext < thr2) begin
			tag_in.qtr = QTR_W'(1);
		end else if (idx_ext < thr3) begin
			tag_in.qtr = QTR_W'(2);
		end else begin
			tag_in.qtr = QTR_W'(3);
		end
	end

	// pipeline flow control
	logic v1_q, v2_q, vo_q;
	logic o_free, go2, s2_free, go1, s1_free, acc_in;

	assign o_free  = !vo_q || res_out.ready;
	assign go2     = v2_q && o_free;
	assign s2_free = !v2_q || go2;
	assign go1     = v1_q && s2_free;
	assign s1_free = !v1_q || go1;
	assign acc_in  = spec_in.valid && s1_free;

	assign spec_in.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q  <= 1'b0;
			v2_q  <= 1'b0;
			vo_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (acc_in) begin
				v1_q <= 1'b1;
			end else if (go1) begin
				v1_q <= 1'b0;
			end
			if (go1) begin
				v2_q <= 1'b1;
			end else if (go2) begin
				v2_q <= 1'b0;
			end
			if (go2) begin
				vo_q <= 1'b1;
			end else if (res_out.ready) begin
				vo_q <= 1'b0;
			end
			if (acc_in) begin
				cnt_q <= tag_in.last ? '0 : cnt_q + IDX_W'(1);
			end
		end
	end

	// stage 1: peak read, stage 2: decay product, then compare and write back.
	// A band address recurs at least four items later, after its write-back.
	mag_t                peak_rd;
	mag_t                mag_s1, mag_s2;
	band_tag_t           tag_s1, tag_s2;
	logic [PROD_W-1:0]   prod_s2;
	mag_t                decayed, sm;

	sphb_peak_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (acc_in),
		.rd_addr (cnt_q),
		.rd_data (peak_rd),
		.wr_en   (go2),
		.wr_addr (tag_s2.idx),
		.wr_data (sm)
	);

	always_ff @(posedge clk) begin
		if (acc_in) begin
			mag_s1 <= spec_in.magnitude;
			tag_s1 <= tag_in;
		end
		if (go1) begin
			prod_s2 <= PROD_W'(peak_rd) * PROD_W'(decay_q);
			mag_s2  <= mag_s1;
			tag_s2  <= tag_s1;
		end
	end

	assign decayed = prod_s2[PROD_W-1:DECAY_W];
	assign sm      = (decayed < mag_s2) ? mag_s2 : decayed;

	// result register
	idx_t         idx_o_q;
	mag_t         sm_o_q;
	logic         last_o_q;
	band_report_t report;

	always_ff @(posedge clk) begin
		if (go2) begin
			idx_o_q  <= tag_s2.idx;
			sm_o_q   <= sm;
			last_o_q <= tag_s2.last;
		end
	end

	sphb_band_sums u_sums (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (go2),
		.smoothed (sm),
		.tag      (tag_s2),
		.report   (report)
	);

	assign res_out.valid             = vo_q;
	assign res_out.band_index        = idx_o_q;
	assign res_out.smoothed          = sm_o_q;
	assign res_out.frame_done        = last_o_q;
	assign res_out.total_sum         = report.total;
	assign res_out.quarter_one_sum   = report.q1;
	assign res_out.quarter_two_sum   = report.q2;
	assign res_out.quarter_three_sum = report.q3;
	assign res_out.quarter_four_sum  = report.q4;

endmodule

`default_nettype wire

>>> src/sphb_peak_mem.sv
// ----------------------------------------------------------------------------
// sphb_peak_mem: held peak store
// One write and one registered read port; per-entry valid bits make
// unwritten entries read as zero right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sphb_peak_mem (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire sphb_pkg::idx_t rd_addr,
	output sphb_pkg::mag_t     rd_data,
	input  wire logic          wr_en,
	input  wire sphb_pkg::idx_t wr_addr,
	input  wire sphb_pkg::mag_t wr_data
);
	import sphb_pkg::*;

	mag_t                   mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] vld_q;
	mag_t                   rdata_q;
	logic                   rvld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rvld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rvld_q ? rdata_q : '0;

endmodule

`default_nettype wire

>>> src/sphb_band_sums.sv
// ----------------------------------------------------------------------------
// sphb_band_sums: frame and quarter accumulators
// Adds each smoothed value into the total and its quarter; on the last band
// the sums go to the report registers and the accumulators restart.
// ----------------------------------------------------------------------------
`default_nettype none

module sphb_band_sums (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire sphb_pkg::mag_t      smoothed,
	input  wire sphb_pkg::band_tag_t tag,
	output sphb_pkg::band_report_t   report
);
	import sphb_pkg::*;

	sum_t total_q;
	sum_t qacc_q [NUM_QTR];
	sum_t total_nxt;
	sum_t qacc_nxt [NUM_QTR];
	sum_t sm_ext;
	band_report_t report_q;

	assign sm_ext    = SUM_W'(smoothed);
	assign total_nxt = total_q + sm_ext;

	always_comb begin
		for (int i = 0; i < NUM_QTR; i++) begin
			qacc_nxt[i] = qacc_q[i] + ((tag.qtr == QTR_W'(i)) ? sm_ext : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			for (int i = 0; i < NUM_QTR; i++) begin
				qacc_q[i] <= '0;
			end
		end else if (en) begin
			if (tag.last) begin
				total_q <= '0;
				for (int i = 0; i < NUM_QTR; i++) begin
					qacc_q[i] <= '0;
				end
			end else begin
				total_q <= total_nxt;
				for (int i = 0; i < NUM_QTR; i++) begin
					qacc_q[i] <= qacc_nxt[i];
				end
			end
		end
	end

	// sums are reported as zero except on the last band
	always_ff @(posedge clk) begin
		if (en) begin
			if (tag.last) begin
				report_q.total <= total_nxt;
				report_q.q1    <= qacc_nxt[0];
				report_q.q2    <= qacc_nxt[1];
				report_q.q3    <= qacc_nxt[2];
				report_q.q4    <= qacc_nxt[3];
			end else begin
				report_q <= '0;
			end
		end
	end

	assign report = report_q;

endmodule

`default_nettype wire
